// ----- src/sdps_pkg.sv -----
`timescale 1ns / 1ps
package sdps_pkg;

   localparam int QUERY_BYTES = 32;
   localparam int QL_W        = 6;
   localparam int SW          = 13;

   typedef enum logic [1:0] {
      FUNC_DICT_WR  = 2'd0,
      FUNC_QUERY_WR = 2'd1,
      FUNC_EXACT    = 2'd2,
      FUNC_PREFIX   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CMP_CONT = 2'd0,
      CMP_EQ   = 2'd1,
      CMP_GT   = 2'd2,
      CMP_LT   = 2'd3
   } cmp_type;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'b001,
      PH_BACK   = 3'b010,
      PH_FWD    = 3'b100
   } phase_type;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_PICK   = 7'b0000010,
      S_LOAD   = 7'b0000100,
      S_CMP    = 7'b0001000,
      S_BSTART = 7'b0010000,
      S_FSTART = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

endpackage

// ----- src/sdps_byte_cmp.sv -----
`timescale 1ns / 1ps
module sdps_byte_cmp
   import sdps_pkg::*;
#(
   parameter int ITEM_BYTES = 32,
   parameter int CW         = 7
) (
   input  logic              exact_mode,
   input  logic              entry_ok,
   input  logic [CW-1:0]     byte_idx,
   input  logic [QL_W-1:0]   query_len,
   input  logic [7:0]        entry_byte,
   input  logic [7:0]        query_byte,
   output cmp_type           result
);

   logic e_end;
   logic q_end;

   assign e_end = !entry_ok || (32'(byte_idx) >= ITEM_BYTES) || (entry_byte == 8'd0);
   assign q_end = 32'(byte_idx) >= 32'(query_len);

   // result gives where the query lies relative to the entry
   always_comb begin
      result = CMP_CONT;
      if (exact_mode) begin
         if (e_end && q_end)              result = CMP_EQ;
         else if (e_end)                  result = CMP_GT;
         else if (q_end)                  result = CMP_LT;
         else if (query_byte > entry_byte) result = CMP_GT;
         else if (query_byte < entry_byte) result = CMP_LT;
      end else begin
         if (q_end)                       result = CMP_EQ;
         else if (e_end)                  result = CMP_GT;
         else if (query_byte > entry_byte) result = CMP_GT;
         else if (query_byte < entry_byte) result = CMP_LT;
      end
   end

endmodule

// ----- src/sorted_dictionary_prefix_search_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   func, entry_index, byte_pos, byte_value,
//                                            query_length, range_first, range_last
// rsp_      out        rsp_valid/rsp_ready   match_index, match_count
// csr_      in         csr_write_enable      csr_write_data (word_count)
//
// Byte writes are stored when accepted. Each search probe passes through pick and load,
// then compares byte positions in turn; prefix widening loads and compares each neighbor
// visited, and each direction begins with its own start state. Reset clears control and
// word_count; memories are undefined until written. Writes are accepted while a result
// waits; a following search stalls at its end until the result is taken.
module sorted_dictionary_prefix_search_top
   import sdps_pkg::*;
#(
   parameter int DICT_DEPTH = 1024,
   parameter int ITEM_BYTES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [9:0]         req_entry_index,
   input  logic [4:0]         req_byte_pos,
   input  logic [7:0]         req_byte_value,
   input  logic [5:0]         req_query_length,
   input  logic [9:0]         req_range_first,
   input  logic signed [10:0] req_range_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [10:0] rsp_match_index,
   output logic [10:0]        rsp_match_count,
   input  logic               csr_write_enable,
   input  logic [10:0]        csr_write_data
);

   localparam int MEM_DEPTH = DICT_DEPTH * ITEM_BYTES;
   localparam int ADW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int MAXB      = (ITEM_BYTES > QUERY_BYTES) ? ITEM_BYTES : QUERY_BYTES;
   localparam int CW        = $clog2(MAXB + 2);

   logic [7:0] dict_mem [MEM_DEPTH];
   logic [7:0] query_mem [QUERY_BYTES];
   logic [7:0] dict_rdata_ff;
   logic [7:0] query_rdata_ff;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic                 exact_ff, exact_in;
   logic [QL_W-1:0]      ql_ff, ql_in;
   logic signed [SW-1:0] first_ff, first_in;
   logic signed [SW-1:0] last_ff, last_in;
   logic signed [SW-1:0] idx_ff, idx_in;
   logic signed [SW-1:0] pos_ff, pos_in;
   logic signed [SW-1:0] found_ff, found_in;
   logic signed [SW-1:0] start_ff, start_in;
   logic signed [SW-1:0] back_ff, back_in;
   logic [SW-1:0]        count_ff, count_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [10:0]          word_count_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [10:0]   rsp_index_ff, rsp_index_in;
   logic [10:0]          rsp_count_ff, rsp_count_in;

   logic signed [SW-1:0] wc;
   logic signed [SW-1:0] mid;
   logic                 entry_ok;
   logic [CW-1:0]        rd_byte;
   logic [ADW-1:0]       rd_addr;
   logic [ADW-1:0]       wr_addr;
   logic [4:0]           q_rd_addr;
   logic                 accept;
   logic                 dict_we;
   logic                 query_we;
   logic                 out_free;
   cmp_type              cmp_res;

   assign wc = (32'(word_count_ff) > DICT_DEPTH) ? SW'(DICT_DEPTH)
                                                 : SW'(word_count_ff);
   assign mid = first_ff + ((last_ff - first_ff) >>> 1);
   assign entry_ok = !idx_ff[SW-1] && (idx_ff < wc);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign dict_we   = accept && (func_type'(req_func) == FUNC_DICT_WR)
                      && (32'(req_entry_index) < DICT_DEPTH)
                      && (32'(req_byte_pos) < ITEM_BYTES);
   assign query_we  = accept && (func_type'(req_func) == FUNC_QUERY_WR);
   assign wr_addr   = ADW'(req_entry_index) * ADW'(ITEM_BYTES) + ADW'(req_byte_pos);

   assign rd_byte   = (state_ff == S_CMP) ? cnt_ff + CW'(1) : '0;
   assign rd_addr   = (entry_ok ? ADW'(idx_ff[SW-2:0]) * ADW'(ITEM_BYTES) : '0)
                      + ((32'(rd_byte) < ITEM_BYTES) ? ADW'(rd_byte) : '0);
   assign q_rd_addr = (32'(rd_byte) < QUERY_BYTES) ? rd_byte[4:0] : '0;

   always_ff @(posedge clock) begin
      if (dict_we) begin
         dict_mem[wr_addr] <= req_byte_value;
      end
      dict_rdata_ff <= dict_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (query_we) begin
         query_mem[req_byte_pos] <= req_byte_value;
      end
      query_rdata_ff <= query_mem[q_rd_addr];
   end

   sdps_byte_cmp #(
      .ITEM_BYTES (ITEM_BYTES),
      .CW         (CW)
   ) u_cmp (
      .exact_mode (exact_ff && (phase_ff == PH_SEARCH)),
      .entry_ok   (entry_ok),
      .byte_idx   (cnt_ff),
      .query_len  (ql_ff),
      .entry_byte (dict_rdata_ff),
      .query_byte (query_rdata_ff),
      .result     (cmp_res)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      exact_in     = exact_ff;
      ql_in        = ql_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      start_in     = start_ff;
      back_in      = back_ff;
      count_in     = count_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_func == FUNC_EXACT || req_func == FUNC_PREFIX)) begin
               exact_in = (func_type'(req_func) == FUNC_EXACT);
               ql_in    = (req_query_length > QL_W'(QUERY_BYTES))
                          ? QL_W'(QUERY_BYTES) : req_query_length;
               first_in = SW'(req_range_first);
               last_in  = SW'(req_range_last);
               found_in = -SW'(1);
               back_in  = '0;
               count_in = '0;
               phase_in = PH_SEARCH;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (first_ff > last_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in   = mid;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cnt_in   = '0;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (cmp_res == CMP_CONT) begin
               cnt_in = cnt_ff + CW'(1);
            end else begin
               case (phase_ff)
                  PH_SEARCH: begin
                     if (cmp_res == CMP_EQ) begin
                        found_in = idx_ff;
                        count_in = SW'(1);
                        start_in = (idx_ff > wc) ? wc : idx_ff;
                        state_in = exact_ff ? S_DONE : S_BSTART;
                     end else if (cmp_res == CMP_GT) begin
                        first_in = idx_ff + SW'(1);
                        state_in = S_PICK;
                     end else begin
                        last_in  = idx_ff - SW'(1);
                        state_in = S_PICK;
                     end
                  end
                  PH_BACK: begin
                     if (cmp_res == CMP_EQ) begin
                        back_in  = back_ff + SW'(1);
                        count_in = count_ff + SW'(1);
                        if (pos_ff > 0) begin
                           if (idx_ff > -SW'(1)) idx_in = idx_ff - SW'(1);
                           pos_in   = pos_ff - SW'(1);
                           state_in = S_LOAD;
                        end else begin
                           state_in = S_FSTART;
                        end
                     end else begin
                        state_in = S_FSTART;
                     end
                  end
                  PH_FWD: begin
                     if (cmp_res == CMP_EQ) begin
                        count_in = count_ff + SW'(1);
                        if (pos_ff < wc - SW'(1)) begin
                           if (idx_ff < wc) idx_in = idx_ff + SW'(1);
                           pos_in   = pos_ff + SW'(1);
                           state_in = S_LOAD;
                        end else begin
                           state_in = S_DONE;
                        end
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_BSTART: begin
            idx_in = start_ff;
            pos_in = found_ff;
            if (found_ff > 0) begin
               if (start_ff > -SW'(1)) idx_in = start_ff - SW'(1);
               pos_in   = found_ff - SW'(1);
               phase_in = PH_BACK;
               state_in = S_LOAD;
            end else begin
               state_in = S_FSTART;
            end
         end
         S_FSTART: begin
            idx_in = start_ff;
            pos_in = found_ff;
            if (found_ff < wc - SW'(1)) begin
               if (start_ff < wc) idx_in = start_ff + SW'(1);
               pos_in   = found_ff + SW'(1);
               phase_in = PH_FWD;
               state_in = S_LOAD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = 11'(found_ff - back_ff);
               rsp_count_in = 11'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_SEARCH;
         rsp_valid_ff  <= 1'b0;
         word_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            word_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      exact_ff     <= exact_in;
      ql_ff        <= ql_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      start_ff     <= start_in;
      back_ff      <= back_in;
      count_ff     <= count_in;
      cnt_ff       <= cnt_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_match_count = rsp_count_ff;

endmodule
